FILE: rtl/nsks_pkg.sv
// nsks_pkg: shared types and constants for the nucleotide seed k-mer scanner
// used by nsks_tables and nucleotide_seed_kmer_scanner_core
`timescale 1ns / 1ps

package nsks_pkg;

  localparam int BACKBONE_AW    = 16;
  localparam int OVERFLOW_DEPTH = 8192;
  localparam int OVF_AW         = $clog2(OVERFLOW_DEPTH);
  localparam int MAX_CHAIN      = 64;
  localparam int CHAIN_CW       = $clog2(MAX_CHAIN + 1);
  localparam int ENTRY_W        = 16;
  localparam int POS_W          = 31;
  localparam int COUNT_W        = 21;
  localparam int RESERVE_W      = 7;
  localparam int QUERY_W        = 15;

  localparam logic [1:0] REQ_BACKBONE = 2'd0;
  localparam logic [1:0] REQ_OVERFLOW = 2'd1;
  localparam logic [1:0] REQ_SUBJECT  = 2'd2;

  localparam logic CFG_HIT_LIMIT     = 1'b0;
  localparam logic CFG_CHAIN_RESERVE = 1'b1;

  localparam logic [COUNT_W-1:0] HIT_LIMIT_RESET = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [ENTRY_W-1:0] ENTRY_NONE      = {ENTRY_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_STEP        = POS_W'(4);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_CHAIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic                   bb_we;
    logic                   ov_we;
    logic                   bb_re;
    logic                   ov_re;
    logic [BACKBONE_AW-1:0] waddr;
    logic [ENTRY_W-1:0]     wdata;
    logic [BACKBONE_AW-1:0] bb_raddr;
    logic [OVF_AW-1:0]      ov_raddr;
  } tbl_ctrl_t;

endpackage

FILE: rtl/nsks_tables.sv
// nsks_tables: backbone and overflow lookup memories, registered reads
// depends on nsks_pkg
`timescale 1ns / 1ps

module nsks_tables (
  input  logic                          clk,
  input  nsks_pkg::tbl_ctrl_t           ctrl,
  output logic [nsks_pkg::ENTRY_W-1:0]  bb_rdata,
  output logic [nsks_pkg::ENTRY_W-1:0]  ov_rdata
);
  import nsks_pkg::*;

  logic [ENTRY_W-1:0] backbone_mem [0:(1 << BACKBONE_AW)-1];
  logic [ENTRY_W-1:0] overflow_mem [0:OVERFLOW_DEPTH-1];

  always_ff @(posedge clk) begin
    if (ctrl.bb_we) begin
      backbone_mem[ctrl.waddr] <= ctrl.wdata;
    end
    if (ctrl.bb_re) begin
      bb_rdata <= backbone_mem[ctrl.bb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ov_we) begin
      overflow_mem[ctrl.waddr[OVF_AW-1:0]] <= ctrl.wdata;
    end
    if (ctrl.ov_re) begin
      ov_rdata <= overflow_mem[ctrl.ov_raddr];
    end
  end

endmodule

FILE: rtl/nucleotide_seed_kmer_scanner_core.sv
// nucleotide_seed_kmer_scanner_core: 8-mer seed scan over a two-level lookup table
// depends on nsks_pkg and nsks_tables
`timescale 1ns / 1ps

// Table loads, scan-start bytes and bytes of a stopped scan are taken on accept
// and leave busy low. For a scanned byte, the accept cycle issues the backbone
// read and the next cycle examines the entry, registering a single hit or a
// limit result. An entry that points into the overflow table starts a chain
// walk in which each chain entry is one overflow read, until a terminator or
// the MAX_CHAIN bound ends it. Results appear on the output ports for exactly
// one cycle, flagged by result_valid, and cannot be held off by the receiver.
// The tables come out of reset undefined and need no clearing pass;
// configuration is to be written through cfg_write, cfg_index and cfg_data
// only while busy is low, which the block itself does not enforce.

module nucleotide_seed_kmer_scanner_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [15:0]                     table_address,
  input  logic signed [15:0]              table_entry,
  input  logic [7:0]                      subject_byte,
  input  logic                            scan_start,
  input  logic [nsks_pkg::POS_W-1:0]      start_position,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [nsks_pkg::COUNT_W-1:0]    cfg_data,
  output logic                            result_valid,
  output logic [nsks_pkg::QUERY_W-1:0]    hit_query,
  output logic [nsks_pkg::POS_W-1:0]      subject_offset,
  output logic                            status,
  output logic                            last
);
  import nsks_pkg::*;

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]   hit_limit;
  logic [RESERVE_W-1:0] chain_reserve;
  logic [7:0]           previous_byte;
  logic [POS_W-1:0]     word_position;
  logic [POS_W-1:0]     hit_pos;
  logic [COUNT_W-1:0]   hit_count;
  logic                 scan_stopped;
  logic [15:0]          chain_addr;
  logic [CHAIN_CW-1:0]  chain_cnt;
  logic                 pend_valid;
  logic [QUERY_W-1:0]   pend_query;

  tbl_ctrl_t            tctl;
  logic [ENTRY_W-1:0]   bb_rdata;
  logic [ENTRY_W-1:0]   ov_rdata;

  logic                 accept;
  logic                 scan_go;
  logic signed [COUNT_W:0] limit;
  logic                 over_limit;
  logic [15:0]          src;
  logic                 src_ok;
  logic                 cur_ok;
  logic [15:0]          chain_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign scan_go = accept && (req_type == REQ_SUBJECT) && !scan_start && !scan_stopped;

  assign limit      = $signed({1'b0, hit_limit}) -
                      $signed({{(COUNT_W + 1 - RESERVE_W){1'b0}}, chain_reserve});
  assign over_limit = $signed({1'b0, hit_count}) > limit;
  assign src        = ~bb_rdata + 16'd1;
  assign src_ok     = {1'b0, src} < 17'(OVERFLOW_DEPTH);
  assign chain_next = chain_addr + 16'd1;
  assign cur_ok     = ({1'b0, chain_addr} < 17'(OVERFLOW_DEPTH)) && !ov_rdata[ENTRY_W-1] &&
                      (chain_cnt < CHAIN_CW'(MAX_CHAIN));

  always_comb begin
    tctl.bb_we    = accept && (req_type == REQ_BACKBONE);
    tctl.ov_we    = accept && (req_type == REQ_OVERFLOW) &&
                    ({1'b0, table_address} < 17'(OVERFLOW_DEPTH));
    tctl.waddr    = table_address;
    tctl.wdata    = table_entry;
    tctl.bb_re    = scan_go;
    tctl.bb_raddr = {previous_byte, subject_byte};
    tctl.ov_re    = 1'b0;
    tctl.ov_raddr = chain_next[OVF_AW-1:0];
    case (state)
      S_LOOKUP: begin
        tctl.ov_re    = (bb_rdata != ENTRY_NONE) && !over_limit && bb_rdata[ENTRY_W-1] &&
                        src_ok;
        tctl.ov_raddr = src[OVF_AW-1:0];
      end
      S_CHAIN: begin
        tctl.ov_re = cur_ok;
      end
      default: begin
      end
    endcase
  end

  nsks_tables u_tables (
    .clk      (clk),
    .ctrl     (tctl),
    .bb_rdata (bb_rdata),
    .ov_rdata (ov_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (scan_go) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (tctl.ov_re) begin
          state_next = S_CHAIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHAIN: begin
        if (!cur_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_limit     <= HIT_LIMIT_RESET;
      chain_reserve <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HIT_LIMIT:     hit_limit     <= cfg_data;
        CFG_CHAIN_RESERVE: chain_reserve <= cfg_data[RESERVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // scan state and chain walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      previous_byte <= '0;
      word_position <= '0;
      hit_count     <= '0;
      scan_stopped  <= 1'b1;
      pend_valid    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (accept && (req_type == REQ_SUBJECT)) begin
        if (scan_start) begin
          previous_byte <= subject_byte;
          word_position <= start_position;
          hit_count     <= '0;
          scan_stopped  <= 1'b0;
        end else if (!scan_stopped) begin
          previous_byte <= subject_byte;
          word_position <= word_position + POS_STEP;
        end
      end
      case (state)
        S_LOOKUP: begin
          if (bb_rdata != ENTRY_NONE) begin
            if (over_limit) begin
              result_valid <= 1'b1;
              status       <= 1'b1;
              last         <= 1'b1;
              scan_stopped <= 1'b1;
            end else if (!bb_rdata[ENTRY_W-1]) begin
              result_valid <= 1'b1;
              status       <= 1'b0;
              last         <= 1'b1;
              if (hit_count != COUNT_MAX) begin
                hit_count <= hit_count + COUNT_W'(1);
              end
            end
          end
          pend_valid <= 1'b0;
        end
        S_CHAIN: begin
          if (cur_ok) begin
            pend_valid <= 1'b1;
            if (hit_count != COUNT_MAX) begin
              hit_count <= hit_count + COUNT_W'(1);
            end
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid) begin
            result_valid <= 1'b1;
            status       <= 1'b0;
            last         <= !cur_ok;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (scan_go) begin
      hit_pos <= word_position;
    end
    case (state)
      S_LOOKUP: begin
        hit_query      <= (over_limit || bb_rdata[ENTRY_W-1]) ? '0 : bb_rdata[QUERY_W-1:0];
        subject_offset <= hit_pos;
        chain_addr     <= src;
        chain_cnt      <= '0;
      end
      S_CHAIN: begin
        hit_query      <= pend_query;
        subject_offset <= hit_pos;
        if (cur_ok) begin
          pend_query <= ov_rdata[QUERY_W-1:0];
          chain_addr <= chain_next;
          chain_cnt  <= chain_cnt + CHAIN_CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result transfer without work in progress");

  a_limit_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> last)
    else $error("limit result not marked last");

  a_limit_stops: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> scan_stopped)
    else $error("scan still running after limit result");

  a_chain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHAIN) |-> (chain_cnt <= CHAIN_CW'(MAX_CHAIN)))
    else $error("chain walk past its hit bound");

endmodule
